/* design/utf8v_pkg.sv */
package utf8v_pkg;

  // Byte masks and bounds used to classify lead and continuation bytes.
  localparam logic [7:0] AsciiMask = 8'h80;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] TwoMask   = 8'hE0;
  localparam logic [7:0] TwoLead   = 8'hC0;
  localparam logic [7:0] TwoMin    = 8'hC2;
  localparam logic [7:0] ThreeMask = 8'hF0;
  localparam logic [7:0] ThreeLead = 8'hE0;
  localparam logic [7:0] FourMask  = 8'hF8;
  localparam logic [7:0] FourLead  = 8'hF0;
  localparam logic [7:0] FourMax   = 8'hF4;

  // Classification of a lead byte: an error mark or the continuations it owes.
  typedef struct packed {
    logic       bad;
    logic [1:0] owed;
  } lead_t;

  function automatic lead_t lead_class(input logic [7:0] b);
    lead_t r;
    r.bad  = 1'b0;
    r.owed = 2'd0;
    if ((b & AsciiMask) == 8'h00) begin
      r.owed = 2'd0;
    end else if ((b & TwoMask) == TwoLead) begin
      r.bad  = (b < TwoMin);
      r.owed = 2'd1;
    end else if ((b & ThreeMask) == ThreeLead) begin
      r.owed = 2'd2;
    end else if ((b & FourMask) == FourLead) begin
      r.bad  = (b > FourMax);
      r.owed = 2'd3;
    end else begin
      r.bad = 1'b1;
    end
    if (r.bad) begin
      r.owed = 2'd0;
    end
    return r;
  endfunction

endpackage

/* design/utf8v_if.sv */
interface utf8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8v_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

/* design/utf8_validator.sv */
// Channel   Dir   Payload                          Transaction
// in_ch     in    data_byte[7:0], last_byte        one byte of the buffer
// out_ch    out   valid_res                        verdict for one whole buffer
//
// One byte is taken every cycle while in_ch.ready is high; a final byte held
// back by a stalled verdict stops the flow. The byte goes into the input
// register when its transaction completes, and a final byte moves its verdict
// into the result register once that register is free; out_ch.valid is driven
// straight from the result register.
// The state update is one classify-and-count step between those two registers.
// rst is synchronous and active high; it empties both stages and clears the
// owed-continuation count and the error flag.
// A stalled verdict holds only a final byte in the input register; other
// bytes keep flowing past it, so in_ch.ready drops only in that one case.
module utf8_validator (
  input  logic           clk,
  input  logic           rst,
  utf8v_in_if.sink       in_ch,
  utf8v_out_if.source    out_ch
);
  import utf8v_pkg::*;

  // Input register stage.
  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;

  // Per-buffer state: continuations still owed and the sticky error flag.
  logic [1:0] pending;
  logic       error_seen;

  // Result register stage.
  logic       res_valid;
  logic       res_value;

  logic       advance;
  logic       res_free;
  lead_t      lead;
  logic [1:0] pending_next;
  logic       error_next;

  // The result register can take a new verdict when empty or being drained.
  assign res_free = !res_valid || out_ch.ready;

  // A byte leaves the input register unless it is a final byte that has no
  // room in the result register.
  assign advance     = in_valid && (!in_last || res_free);
  assign in_ch.ready = !in_valid || advance;

  assign out_ch.valid     = res_valid;
  assign out_ch.valid_res = res_value;

  // Classify the byte in the input register and update the count. While a
  // sequence is open the byte must be a continuation; otherwise it is a lead.
  always_comb begin
    lead         = lead_class(in_data);
    pending_next = pending;
    error_next   = error_seen;
    if (pending != 2'd0) begin
      if ((in_data & ContMask) == ContTag) begin
        pending_next = pending - 2'd1;
      end else begin
        error_next   = 1'b1;
        pending_next = 2'd0;
      end
    end else begin
      pending_next = lead.owed;
      if (lead.bad) begin
        error_next = 1'b1;
      end
    end
  end

  // Input register: loads whenever it is empty or its byte moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data <= in_ch.data_byte;
      in_last <= in_ch.last_byte;
    end
  end

  // Buffer state: a final byte returns it to the reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 2'd0;
      error_seen <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        pending    <= 2'd0;
        error_seen <= 1'b0;
      end else begin
        pending    <= pending_next;
        error_seen <= error_next;
      end
    end
  end

  // Result register: the buffer is good when no error was seen and no
  // sequence is left open after its final byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && in_last) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      res_value <= !error_next && (pending_next == 2'd0);
    end
  end

endmodule

/* design/utf8v_checker.sv */
module utf8v_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_res
);

  // A verdict that is not taken stays, with its value unchanged.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("verdict changed or dropped while stalled");

  // Reset leaves no verdict pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("verdict present after reset");

  // The input side only stalls behind a verdict that waits to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting verdict");

  // A final byte taken while a verdict waits blocks the input until it drains.
  a_one_ahead: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last && out_valid && !out_ready
    |=> !in_ready || out_ready)
    else $error("input ran ahead of a stalled verdict");

endmodule

bind utf8_validator utf8v_checker u_utf8v_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_res   (out_ch.valid_res)
);

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

  // One queued byte of stimulus. When hold is set, the driver keeps this byte
  // back until every verdict owed so far has been returned by the block.
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         hold;
  } stim_byte_t;

  // Marker for a byte that cannot open a UTF-8 sequence.
  localparam int NotALead = -1;

  // The run is short. This bound still leaves a wide margin over the slowest
  // legal run, including every stall burst on both sides.
  localparam int LimitCycles = 200000;
  // Bytes left in the queue when the final stretch without idling starts.
  localparam int TailBytes   = 250;
  // Number of random stimulus bytes to generate.
  localparam int RandomBytes = 1750;

  logic clk = 1'b0;
  logic rst;

  utf8v_in_if  in_ch();
  utf8v_out_if out_ch();

  utf8_validator u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stimulus store, the expected verdicts, and the predictor's own copy of the
  // block state.
  stim_byte_t pending_bytes[$];
  logic       expected_verdicts[$];
  logic [7:0] chunk[$];
  bit         hold_next;
  logic [1:0] owed;
  bit         bad_seen;

  // Counters that the driver, the monitor and the end-of-run logic share. They
  // are only updated with nonblocking assignments so that every process sees
  // the values from before the clock edge; the mismatch count is the one
  // exception, and only the report task changes it.
  int  verdicts_due;
  int  verdicts_got;
  bit  all_sent;
  bit  calm;
  int  mismatches;
  int  cycle_count;

  // Driver-local state.
  bit         took;
  bit         presenting;
  int         gap_left;
  stim_byte_t nxt;

  // Monitor-local state.
  int   stall_left;
  logic want;

  task automatic report(input string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Number of continuation bytes that a lead byte calls for, or NotALead.
  // C0 and C1 would only encode overlong forms, and leads above F4 lie past
  // the last code point, so both are rejected.
  function automatic int lead_owes(input logic [7:0] b);
    casez (b)
      8'b0???????: return 0;
      8'b110?????: return (b < 8'hC2) ? NotALead : 1;
      8'b1110????: return 2;
      8'b11110???: return (b > 8'hF4) ? NotALead : 3;
      default:     return NotALead;
    endcase
  endfunction

  // Advances the predicted state by one accepted byte. On the final byte of a
  // buffer it files the verdict and starts over with a clean state.
  task automatic track_byte(input logic [7:0] b, input logic fin);
    int k;
    if (owed != 2'd0) begin
      // Inside a sequence, only a 10xxxxxx byte is allowed.
      if (b[7:6] == 2'b10) begin
        owed = owed - 2'd1;
      end else begin
        bad_seen = 1'b1;
        owed     = 2'd0;
      end
    end else begin
      k = lead_owes(b);
      if (k == NotALead) begin
        bad_seen = 1'b1;
        owed     = 2'd0;
      end else begin
        owed = k[1:0];
      end
    end
    if (fin) begin
      // A sequence still open at the end makes the buffer invalid as well.
      expected_verdicts = {expected_verdicts, (!bad_seen && owed == 2'd0)};
      owed     = 2'd0;
      bad_seen = 1'b0;
    end
  endtask

  // Moves the bytes gathered in chunk into the stimulus queue as one buffer.
  // The final byte carries the last mark, so no buffer is ever empty.
  task automatic flush_chunk();
    stim_byte_t it;
    for (int i = 0; i < chunk.size(); i++) begin
      it.data = chunk[i];
      it.last = (i == chunk.size() - 1);
      it.hold = (i == 0) && hold_next;
      pending_bytes = {pending_bytes, it};
    end
    hold_next = 1'b0;
    chunk.delete();
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Appends one well-formed character of random length to chunk.
  task automatic add_char();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      chunk = {chunk, 8'($urandom_range(8'h00, 8'h7F))};
    end else if (kind < 6) begin
      chunk = {chunk, 8'($urandom_range(8'hC2, 8'hDF))};
      chunk = {chunk, cont_byte()};
    end else if (kind < 8) begin
      chunk = {chunk, 8'($urandom_range(8'hE0, 8'hEF))};
      chunk = {chunk, cont_byte()};
      chunk = {chunk, cont_byte()};
    end else begin
      chunk = {chunk, 8'($urandom_range(8'hF0, 8'hF4))};
      chunk = {chunk, cont_byte()};
      chunk = {chunk, cont_byte()};
      chunk = {chunk, cont_byte()};
    end
  endtask

  // Builds one random buffer. Most buffers are well-formed text; the rest
  // have one byte replaced, lose their final byte, or are pure noise.
  task automatic add_random_buffer();
    int chars;
    int mode;
    int pos;
    chars = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
    mode  = $urandom_range(0, 9);
    if (mode == 0) begin
      for (int i = 0; i < $urandom_range(1, 6); i++) begin
        chunk = {chunk, 8'($urandom_range(0, 255))};
      end
    end else begin
      for (int i = 0; i < chars; i++) begin
        add_char();
      end
      if (mode == 1) begin
        pos        = $urandom_range(0, chunk.size() - 1);
        chunk[pos] = 8'($urandom_range(0, 255));
      end else if (mode == 2 && chunk.size() > 1) begin
        void'(chunk.pop_back());
      end
    end
    flush_chunk();
  endtask

  // Driver: presents queued bytes, holds a byte until it is accepted, and
  // inserts short idle bursts between transactions. Each accepted byte goes
  // through the predictor at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      owed         = 2'd0;
      bad_seen     = 1'b0;
      gap_left     = 0;
      all_sent    <= 1'b0;
    end else begin
      took       = in_ch.valid && in_ch.ready;
      presenting = 1'b0;
      if (took) begin
        track_byte(in_ch.data_byte, in_ch.last_byte);
        if (in_ch.last_byte) begin
          verdicts_due <= verdicts_due + 1;
        end
      end
      if (in_ch.valid && !took) begin
        // The block is stalling; the same transaction stays on the bus.
        presenting = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (pending_bytes[0].hold && (took || verdicts_due != verdicts_got)) begin
        // Pause until the block has returned every verdict owed so far. A
        // byte taken at this edge may be a final one that the counter does
        // not show yet, so wait in that case as well.
        in_ch.valid <= 1'b0;
      end else begin
        nxt = pending_bytes.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= nxt.data;
        in_ch.last_byte <= nxt.last;
        presenting = 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(1, 3);
        end
      end
      // Idling stops near the end and in some stretches in the middle.
      calm     <= (pending_bytes.size() < TailBytes) ||
                  ((pending_bytes.size() / 150) % 4 == 2);
      all_sent <= (pending_bytes.size() == 0) && !presenting;
    end
  end

  // Monitor: takes each verdict transaction, checks it against the oldest
  // expectation, and stalls the block in short random bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        verdicts_got <= verdicts_got + 1;
        if (expected_verdicts.size() == 0) begin
          report($sformatf("verdict %0b arrived with none expected", out_ch.valid_res));
        end else begin
          want = expected_verdicts.pop_front();
          if (out_ch.valid_res !== want) begin
            report($sformatf("valid_res is %0b, expected %0b", out_ch.valid_res, want));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left    = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LimitCycles) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[utf8_validator] ERROR");
      $finish;
    end
  end

  initial begin
    int random_count;
    int next_hold;

    // Every input of the block is known from time zero.
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.last_byte  = 1'b0;
    out_ch.ready     = 1'b0;
    verdicts_due     = 0;
    verdicts_got     = 0;
    mismatches       = 0;
    cycle_count      = 0;
    calm             = 1'b0;
    all_sent         = 1'b0;
    hold_next        = 1'b0;

    // Directed buffers. Single bytes at both ends of ASCII, the smallest and
    // largest two- and three-byte leads and the largest four-byte lead, with
    // extreme continuation bytes, a rejected two-byte lead, a lead past the last
    // code point, a byte that can never start a sequence, a stray continuation, a
    // wrong continuation, a sequence still open at the end, and one buffer whose
    // error is followed by more bytes.
    chunk = '{8'h00};                      flush_chunk();
    chunk = '{8'h7F};                      flush_chunk();
    chunk = '{8'hC2, 8'h80};               flush_chunk();
    chunk = '{8'hDF, 8'hBF};               flush_chunk();
    chunk = '{8'hC1, 8'hBF};               flush_chunk();
    chunk = '{8'hE0, 8'h80, 8'h80};        flush_chunk();
    chunk = '{8'hEF, 8'hBF, 8'hBF};        flush_chunk();
    chunk = '{8'hF4, 8'hBF, 8'hBF, 8'hBF}; flush_chunk();
    chunk = '{8'hF7};                      flush_chunk();
    chunk = '{8'hFF};                      flush_chunk();
    chunk = '{8'h80};                      flush_chunk();
    chunk = '{8'hC2, 8'h41};               flush_chunk();
    chunk = '{8'hE1, 8'h80};               flush_chunk();

    // The random part starts only when the directed verdicts are all back,
    // and it pauses the same way every few hundred bytes.
    hold_next    = 1'b1;
    random_count = 0;
    next_hold    = 450;
    while (random_count < RandomBytes) begin
      if (random_count >= next_hold) begin
        hold_next = 1'b1;
        next_hold += 450;
      end
      random_count -= pending_bytes.size();
      add_random_buffer();
      random_count += pending_bytes.size();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last byte to be taken and its verdict to come back, then
    // give the two-stage pipeline time to show any stray verdict.
    while (!(all_sent && verdicts_got == verdicts_due)) @(posedge clk);
    repeat (8) @(posedge clk);

    if (expected_verdicts.size() != 0) begin
      report($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
    end
    if (mismatches == 0) begin
      $display("[utf8_validator] OK");
    end else begin
      $display("[utf8_validator] ERROR");
    end
    $finish;
  end

endmodule

/* utf8_validator.f */
design/utf8v_pkg.sv
design/utf8v_if.sv
design/utf8_validator.sv
design/utf8v_checker.sv
verif/tb.sv
